### rtl/assert_macros.svh
// Assertion macros shared by the waveshaper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// cons holds in the cycle in which ante holds
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// cons holds in the cycle after ante holds
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/wci_pkg.sv
// Package for the waveshaper curve interpolator: sizes, codes and types.
package wci_pkg;

   localparam int CURVE_DEPTH   = 1024;
   localparam int SAMPLE_BITS   = 16;
   localparam int FRAC_BITS     = 16;
   localparam int LEN_W         = 11;
   localparam int ENTRY_INDEX_W = 10;

   localparam int IDX_W   = (CURVE_DEPTH > 1) ? $clog2(CURVE_DEPTH) : 1;
   localparam int PROD_W  = SAMPLE_BITS + IDX_W;
   localparam int POS_W   = IDX_W + FRAC_BITS;
   localparam int POS_SHL = (SAMPLE_BITS < FRAC_BITS) ? FRAC_BITS - SAMPLE_BITS : 0;
   localparam int POS_SHR = (SAMPLE_BITS > FRAC_BITS) ? SAMPLE_BITS - FRAC_BITS : 0;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } wci_op_type;

   typedef enum logic [1:0] {
      MODE_SHAPE,
      MODE_BYPASS,
      MODE_MUTE
   } wci_mode_type;

   typedef logic signed [SAMPLE_BITS-1:0] wci_sample_type;
   typedef logic [IDX_W-1:0]              wci_addr_type;

   typedef struct packed {
      logic         is_sample;
      wci_mode_type mode;
      logic         eob;
   } wci_tag_type;

endpackage

### rtl/wci_intf.sv
// Channel interfaces: sample/load request, shaped response, curve length write.
interface wci_req_intf import wci_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                     connected;
   logic [ENTRY_INDEX_W-1:0] entry_index;
   logic signed [SAMPLE_BITS-1:0] entry_value;
   logic                     end_of_block;

   modport source (output valid, op, sample, connected, entry_index, entry_value,
                   end_of_block, input ready);
   modport sink   (input valid, op, sample, connected, entry_index, entry_value,
                   end_of_block, output ready);
endinterface

interface wci_rsp_intf import wci_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] shaped_sample;
   logic                          block_end;

   modport source (output valid, shaped_sample, block_end, input ready);
   modport sink   (input valid, shaped_sample, block_end, output ready);
endinterface

interface wci_csr_intf import wci_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] len_value;

   modport source (output valid, len_value, input ready);
   modport sink   (input valid, len_value, output ready);
endinterface

### rtl/wci_ram.sv
// Generic RAM: one write port, two registered read ports.
module wci_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr_a,
   input  logic [AW-1:0]    raddr_b,
   output logic [WIDTH-1:0] rdata_a,
   output logic [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

### rtl/wci_interp.sv
// Interpolation stage: fraction times neighbor difference, floor, output select.
`include "assert_macros.svh"

module wci_interp import wci_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  wci_tag_type    in_tag,
   input  wci_sample_type in_c1,
   input  wci_sample_type in_c2,
   input  logic [FRAC_BITS-1:0] in_frac,
   input  wci_sample_type in_sample,
   output logic           out_valid,
   output wci_tag_type    out_tag,
   output wci_sample_type out_result
);

   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int PW     = FRAC_BITS + SAMPLE_BITS + 2;

   logic signed [DIFF_W-1:0] diff;
   logic signed [PW-1:0]     prod_in;
   logic signed [PW-1:0]     prod_ff;
   logic                     valid_ff;
   wci_tag_type              tag_ff;
   wci_sample_type           c1_ff;
   wci_sample_type           c2_ff;
   wci_sample_type           sample_ff;
   logic signed [PW-1:0]     step;
   logic signed [PW-1:0]     sum;
   wci_sample_type           shaped;

   always_comb begin
      diff    = DIFF_W'(in_c2) - DIFF_W'(in_c1);
      prod_in = $signed({1'b0, in_frac}) * diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff    <= in_tag;
         c1_ff     <= in_c1;
         c2_ff     <= in_c2;
         sample_ff <= in_sample;
         prod_ff   <= prod_in;
      end
   end

   always_comb begin
      step   = prod_ff >>> FRAC_BITS;
      sum    = PW'(c1_ff) + step;
      shaped = sum[SAMPLE_BITS-1:0];
      case (tag_ff.mode)
         MODE_SHAPE:  out_result = shaped;
         MODE_BYPASS: out_result = sample_ff;
         MODE_MUTE:   out_result = '0;
         default:     out_result = '0;
      endcase
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;

   `ASSERT_IMPLY(a_between_neighbors, valid_ff && tag_ff.is_sample && tag_ff.mode == MODE_SHAPE,
      (shaped >= c1_ff && shaped <= c2_ff) || (shaped <= c1_ff && shaped >= c2_ff))
   `ASSERT_IMPLY(a_mute_is_zero, valid_ff && tag_ff.mode == MODE_MUTE, out_result == '0)
   `ASSERT_NEXT(a_hold_on_stall, valid_ff && tag_ff.is_sample && !en, valid_ff && $stable(out_result))

endmodule

### rtl/waveshaper_curve_interp_core.sv
// Waveshaper core: a sample word is mapped onto the curve, the two neighbor
// entries are read from the curve RAM and interpolated with a 16-bit fraction,
// rounded toward minus infinity. Load words write one curve entry and give no
// response. One word is taken per clock, and the pipeline stalls only while a
// response waits on rsp_ch.ready. The two-read-port curve RAM, shared in program
// order by writes and reads in one stage, sets that rate. The curve RAM needs no
// clearing after reset; an entry must be loaded before a sample reads it. The
// curve length may only be written while no word is in flight; 0 passes connected
// samples through unchanged.
`include "assert_macros.svh"

module waveshaper_curve_interp_core import wci_pkg::*; (
   input logic        clock,
   input logic        reset,
   wci_req_intf.sink  req_ch,
   wci_rsp_intf.source rsp_ch,
   wci_csr_intf.sink  csr_ch
);

   logic           adv;

   int             len_clamp;
   logic           len_zero_in;
   logic           len_zero_ff;
   wci_addr_type   len_m1_in;
   wci_addr_type   len_m1_ff;

   logic [SAMPLE_BITS-1:0] u;
   wci_tag_type    s1_tag_in;
   logic [PROD_W-1:0] s1_prod_in;
   logic           s1_wok_in;
   logic           s1_valid_ff;
   wci_tag_type    s1_tag_ff;
   wci_sample_type s1_sample_ff;
   logic [PROD_W-1:0] s1_prod_ff;
   logic           s1_wok_ff;
   wci_addr_type   s1_waddr_ff;
   wci_sample_type s1_wval_ff;

   logic [PROD_W+POS_SHL-1:0] wide;
   logic [POS_W-1:0] pos;
   wci_addr_type   i1_raw;
   wci_addr_type   i1;
   wci_addr_type   i2;
   logic [FRAC_BITS-1:0] frac_in;
   logic           ram_we;
   logic           ram_re;
   logic [SAMPLE_BITS-1:0] c1_raw;
   logic [SAMPLE_BITS-1:0] c2_raw;

   logic           s2_valid_ff;
   wci_tag_type    s2_tag_ff;
   wci_sample_type s2_sample_ff;
   logic [FRAC_BITS-1:0] s2_frac_ff;

   logic           s3_valid;
   wci_tag_type    s3_tag;
   wci_sample_type s3_result;

   logic           rsp_valid_in;
   logic           rsp_valid_ff;
   wci_sample_type rsp_sample_ff;
   logic           rsp_eob_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   // curve length register, clamped to the RAM depth
   always_comb begin
      len_clamp = int'(csr_ch.len_value);
      if (len_clamp > CURVE_DEPTH) begin
         len_clamp = CURVE_DEPTH;
      end
      len_zero_in = (len_clamp == 0);
      len_m1_in   = IDX_W'(len_clamp - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_zero_ff <= 1'b1;
         len_m1_ff   <= '0;
      end else if (csr_ch.valid) begin
         len_zero_ff <= len_zero_in;
         len_m1_ff   <= len_m1_in;
      end
   end

   // stage 1: offset sample times (length - 1)
   always_comb begin
      u          = {~req_ch.sample[SAMPLE_BITS-1], req_ch.sample[SAMPLE_BITS-2:0]};
      s1_prod_in = PROD_W'(u) * PROD_W'(len_m1_ff);
      s1_wok_in  = int'(req_ch.entry_index) < CURVE_DEPTH;
      s1_tag_in.is_sample = (req_ch.op == OP_SAMPLE);
      s1_tag_in.eob       = req_ch.end_of_block;
      if (!req_ch.connected) begin
         s1_tag_in.mode = MODE_MUTE;
      end else if (len_zero_ff) begin
         s1_tag_in.mode = MODE_BYPASS;
      end else begin
         s1_tag_in.mode = MODE_SHAPE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff    <= s1_tag_in;
         s1_sample_ff <= req_ch.sample;
         s1_prod_ff   <= s1_prod_in;
         s1_wok_ff    <= s1_wok_in;
         s1_waddr_ff  <= IDX_W'(req_ch.entry_index);
         s1_wval_ff   <= req_ch.entry_value;
      end
   end

   // stage 2: neighbor addresses, curve RAM access in word order
   always_comb begin
      wide    = (PROD_W + POS_SHL)'(s1_prod_ff) << POS_SHL;
      pos     = POS_W'(wide >> POS_SHR);
      i1_raw  = pos[POS_W-1:FRAC_BITS];
      frac_in = pos[FRAC_BITS-1:0];
      i1      = (i1_raw > len_m1_ff) ? len_m1_ff : i1_raw;
      i2      = (i1 == len_m1_ff) ? len_m1_ff : i1 + 1'b1;
      ram_we  = adv && s1_valid_ff && !s1_tag_ff.is_sample && s1_wok_ff;
      ram_re  = adv && s1_valid_ff && s1_tag_ff.is_sample;
   end

   wci_ram #(
      .DEPTH (CURVE_DEPTH),
      .WIDTH (SAMPLE_BITS)
   ) u_curve_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (s1_waddr_ff),
      .wdata   (s1_wval_ff),
      .re      (ram_re),
      .raddr_a (i1),
      .raddr_b (i2),
      .rdata_a (c1_raw),
      .rdata_b (c2_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_tag_ff    <= s1_tag_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_frac_ff   <= frac_in;
      end
   end

   // stage 3: interpolation
   wci_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (s2_valid_ff),
      .in_tag     (s2_tag_ff),
      .in_c1      (wci_sample_type'(c1_raw)),
      .in_c2      (wci_sample_type'(c2_raw)),
      .in_frac    (s2_frac_ff),
      .in_sample  (s2_sample_ff),
      .out_valid  (s3_valid),
      .out_tag    (s3_tag),
      .out_result (s3_result)
   );

   // output register; load words drop out here
   assign rsp_valid_in = s3_valid && s3_tag.is_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_sample_ff <= s3_result;
         rsp_eob_ff    <= s3_tag.eob;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.shaped_sample = rsp_sample_ff;
   assign rsp_ch.block_end     = rsp_eob_ff;

   `ASSERT_ALWAYS(a_ram_one_access, !(ram_we && ram_re))
   `ASSERT_IMPLY(a_stall_blocks_input, rsp_valid_ff && !rsp_ch.ready, !req_ch.ready)
   `ASSERT_NEXT(a_load_no_response, adv && s3_valid && !s3_tag.is_sample, !rsp_valid_ff)

endmodule

### sim/tb.sv
// Testbench for waveshaper_curve_interp_core: random curve loads and samples against a predictor.
`timescale 1ns / 1ps

module tb;
   import wci_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN       = 12;
   localparam int MAX_PRINTS  = 40;

   typedef struct {
      wci_op_type               op;
      wci_sample_type           sample;
      logic                     connected;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      wci_sample_type           entry_value;
      logic                     end_of_block;
   } req_word_type;

   typedef struct {
      wci_sample_type shaped;
      logic           block_end;
   } shaped_word_type;

   logic clock = 1'b0;
   logic reset;

   wci_req_intf req_ch ();
   wci_rsp_intf rsp_ch ();
   wci_csr_intf csr_ch ();

   waveshaper_curve_interp_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   req_word_type    req_words [$];
   shaped_word_type shaped_q [$];
   wci_sample_type  curve_mem [CURVE_DEPTH];
   bit              curve_loaded [CURVE_DEPTH];
   logic [LEN_W-1:0] curve_len = '0;

   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   bit  req_fire      = 1'b0;
   int  err_count     = 0;
   int  checked       = 0;
   int  samples_sent  = 0;
   int  loads_sent    = 0;
   int  lengths_set   = 0;
   int  cycles        = 0;

   int send_idle_by_mode [4] = '{0, 66, 0, 12};
   int stall_by_mode [4]     = '{0, 0, 66, 12};
   logic [LEN_W-1:0] phase_len [8] = '{11'd1024, 11'd3, 11'd2047, 11'd17,
                                       11'd1025, 11'd1, 11'd700, 11'd0};

   // neighbor entries and fraction for a sample at a given curve length (len > 0)
   function automatic void curve_span(input wci_sample_type s, input logic [LEN_W-1:0] len,
                                      output wci_addr_type lo, output wci_addr_type hi,
                                      output logic [FRAC_BITS-1:0] frac);
      int unsigned            span;
      logic [SAMPLE_BITS-1:0] u;
      logic [POS_W-1:0]       pos;
      span = (len > CURVE_DEPTH) ? CURVE_DEPTH - 1 : len - 1;
      u    = {~s[SAMPLE_BITS-1], s[SAMPLE_BITS-2:0]};
      pos  = POS_W'(u * span);
      lo   = pos[POS_W-1:FRAC_BITS];
      frac = pos[FRAC_BITS-1:0];
      hi   = (lo + 1'b1 > span) ? lo : lo + 1'b1;
   endfunction

   function automatic wci_sample_type shape_sample(input wci_sample_type s, input logic live);
      wci_addr_type          lo;
      wci_addr_type          hi;
      logic [FRAC_BITS-1:0]  frac;
      longint                diff;
      longint                bend;
      if (!live)
         return '0;
      if (curve_len == 0)
         return s;
      curve_span(s, curve_len, lo, hi, frac);
      diff = longint'(curve_mem[hi]) - longint'(curve_mem[lo]);
      bend = (longint'(frac) * diff) >>> FRAC_BITS;
      return wci_sample_type'(longint'(curve_mem[lo]) + bend);
   endfunction

   function automatic void queue_load(input wci_addr_type idx, input wci_sample_type val);
      req_word_type w;
      w.op           = OP_LOAD;
      w.sample       = wci_sample_type'($urandom);
      w.connected    = 1'($urandom);
      w.entry_index  = idx;
      w.entry_value  = val;
      w.end_of_block = 1'($urandom);
      curve_loaded[idx] = 1'b1;
      req_words.push_back(w);
      loads_sent++;
   endfunction

   // loads any curve entry the sample would read that has not been written yet
   function automatic void queue_sample(input wci_sample_type s, input logic live,
                                        input logic eob);
      req_word_type         w;
      wci_addr_type         lo;
      wci_addr_type         hi;
      logic [FRAC_BITS-1:0] frac;
      if (curve_len != 0) begin
         curve_span(s, curve_len, lo, hi, frac);
         if (!curve_loaded[lo])
            queue_load(lo, wci_sample_type'($urandom));
         if (!curve_loaded[hi])
            queue_load(hi, wci_sample_type'($urandom));
      end
      w.op           = OP_SAMPLE;
      w.sample       = s;
      w.connected    = live;
      w.entry_index  = ENTRY_INDEX_W'($urandom);
      w.entry_value  = wci_sample_type'($urandom);
      w.end_of_block = eob;
      req_words.push_back(w);
      samples_sent++;
   endfunction

   function automatic wci_sample_type pick_sample();
      case ($urandom_range(15))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return wci_sample_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("[%0t] %s", $time, what);
   endtask

   task automatic wait_idle(input int drain);
      do @(posedge clock);
      while (req_words.size() != 0 || req_ch.valid || shaped_q.size() != 0);
      repeat (drain) @(posedge clock);
   endtask

   task automatic write_len_reg(input logic [LEN_W-1:0] len);
      @(negedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.len_value <= len;
      do @(posedge clock);
      while (!csr_ch.ready);
      curve_len = len;
      lengths_set++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [LEN_W-1:0] len, input int mode, input int words,
                            input bit pause_mid);
      wait_idle(DRAIN);
      send_idle_pct = send_idle_by_mode[mode];
      stall_pct     = stall_by_mode[mode];
      write_len_reg(len);
      for (int n = 0; n < words; n++) begin
         if (pause_mid && n == words / 2)
            wait_idle(0);
         if ($urandom_range(99) < 20)
            queue_load(IDX_W'($urandom_range(CURVE_DEPTH - 1)), wci_sample_type'($urandom));
         else
            queue_sample(pick_sample(), $urandom_range(99) < 90, 1'($urandom));
      end
   endtask

   // request driver
   always @(negedge clock) begin
      req_word_type w;
      if (req_fire || !req_ch.valid) begin
         if (req_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = req_words.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.op           <= w.op;
            req_ch.sample       <= w.sample;
            req_ch.connected    <= w.connected;
            req_ch.entry_index  <= w.entry_index;
            req_ch.entry_value  <= w.entry_value;
            req_ch.end_of_block <= w.end_of_block;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // monitor: predicts on accepted request words, checks accepted response words
   always @(posedge clock) begin
      shaped_word_type want;
      shaped_word_type got;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (req_fire) begin
         if (req_ch.op == OP_LOAD) begin
            curve_mem[req_ch.entry_index] = req_ch.entry_value;
         end else begin
            want.shaped    = shape_sample(req_ch.sample, req_ch.connected);
            want.block_end = req_ch.end_of_block;
            shaped_q.push_back(want);
         end
      end
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         got.shaped    = rsp_ch.shaped_sample;
         got.block_end = rsp_ch.block_end;
         if (shaped_q.size() == 0) begin
            report_mismatch($sformatf("response word %0d with no sample outstanding",
                                      got.shaped));
         end else begin
            want = shaped_q.pop_front();
            if (got.shaped !== want.shaped)
               report_mismatch($sformatf("shaped_sample: got %0d, want %0d (len %0d)",
                                         got.shaped, want.shaped, curve_len));
            if (got.block_end !== want.block_end)
               report_mismatch($sformatf("block_end: got %b, want %b",
                                         got.block_end, want.block_end));
            checked++;
         end
      end
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run timed out after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.op           = OP_LOAD;
      req_ch.sample       = '0;
      req_ch.connected    = 1'b0;
      req_ch.entry_index  = '0;
      req_ch.entry_value  = '0;
      req_ch.end_of_block = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.len_value    = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pass-through and silence
      write_len_reg(11'd0);
      queue_sample(16'sh8000, 1'b1, 1'b0);
      queue_sample(16'sh7fff, 1'b1, 1'b1);
      queue_sample(16'sh0000, 1'b1, 1'b0);
      queue_sample(16'shffff, 1'b0, 1'b1);
      queue_sample(16'sh3039, 1'b0, 1'b0);
      wait_idle(DRAIN);

      // single entry curve
      write_len_reg(11'd1);
      queue_load(10'd0, 16'sh7fff);
      queue_sample(16'sh8000, 1'b1, 1'b0);
      queue_sample(16'sh7fff, 1'b1, 1'b1);
      queue_sample(16'shffff, 1'b1, 1'b0);
      wait_idle(DRAIN);

      // two entries, full swing, then an overwrite read right behind it
      write_len_reg(11'd2);
      queue_load(10'd0, 16'sh8000);
      queue_load(10'd1, 16'sh7fff);
      queue_load(10'd1023, 16'shffff);
      queue_sample(16'sh8000, 1'b1, 1'b0);
      queue_sample(16'sh0000, 1'b1, 1'b0);
      queue_sample(16'sh7fff, 1'b1, 1'b1);
      queue_sample(16'shffff, 1'b1, 1'b0);
      queue_sample(16'sh0001, 1'b0, 1'b1);
      queue_load(10'd1, 16'sh8000);
      queue_sample(16'sh4000, 1'b1, 1'b0);

      for (int p = 0; p < 8; p++)
         run_phase(phase_len[p], p % 4, 200, p == 1);

      wait_idle(DRAIN);
      $display("Covered %0d sample words and %0d curve loads over %0d curve lengths",
               samples_sent, loads_sent, lengths_set);
      $display("Checked %0d shaped responses in %0d cycles", checked, cycles);
      if (err_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
